>>> hw/rtl/utf8d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_pkg: shared types and constants for the UTF-8 codepoint decoder
// Holds the decoder state record, the per-byte decode result and the
// replacement codepoint.
// ----------------------------------------------------------------------------
package utf8d_pkg;

	localparam int unsigned CP_W      = 21;
	localparam int unsigned PARTIAL_W = 15;
	localparam int unsigned PEND_W    = 2;

	// Replacement character for bad or truncated sequences
	localparam logic [CP_W-1:0] INVALID_CP = 21'h00FFFD;

	// Open-sequence state: continuation bytes still expected and gathered bits
	typedef struct packed {
		logic [PEND_W-1:0]    pending;
		logic [PARTIAL_W-1:0] bits;
	} utf8d_state_t;

	// Outcome of decoding one byte
	typedef struct packed {
		logic            emit;
		logic [CP_W-1:0] codepoint;
		logic            malformed;
	} utf8d_result_t;

endpackage

>>> hw/rtl/utf8_codepoint_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_codepoint_decoder: UTF-8 byte stream to codepoint decoder
// Registers incoming bytes, decodes them against the open-sequence state and
// presents completed codepoints from an output register.
// ----------------------------------------------------------------------------
// The decoder takes one byte request per cycle while in_ready is high and
// returns at most one codepoint per byte: ASCII bytes come out at once,
// multi-byte sequences come out on their last continuation byte, and bytes
// that only extend an open sequence return nothing. An accepted byte lands in
// the input register and its result then in the result register, from which
// the codepoint shows on the output. The sustained rate is one byte per
// cycle while the output side is not stalled, set by the state update in
// the decode step. Malformed input (a bad lead byte, a non-continuation
// byte inside a sequence, which is consumed, or a sequence still open on the
// byte flagged end_of_text) returns 0xFFFD with malformed set. No overlong
// or surrogate checks are made. in_ready drops only while both the input
// register and the output register hold requests and the output side is
// stalled.
// ----------------------------------------------------------------------------
module utf8_codepoint_decoder
	import utf8d_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      text_byte,
	input  logic            end_of_text,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [CP_W-1:0] codepoint,
	output logic            malformed
);

	// input register stage
	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          last_s1;

	// sequence state and result register
	utf8d_state_t  seq_q;
	utf8d_state_t  seq_nxt;
	utf8d_result_t dec_res;
	logic          valid_s2;
	logic [CP_W-1:0] cp_s2;
	logic          bad_s2;

	logic          out_free;
	logic          s1_fire;

	// result register can load when empty or being drained this cycle
	assign out_free = !valid_s2 || out_ready;
	// the stage-one byte is decoded whenever its result has somewhere to go
	assign s1_fire  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	utf8d_decode u_decode (
		.text_byte   (byte_s1),
		.end_of_text (last_s1),
		.cur         (seq_q),
		.nxt         (seq_nxt),
		.res         (dec_res)
	);

	// Advance the input register; hold it while the result side is stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= text_byte;
			last_s1 <= end_of_text;
		end
	end

	// Update the sequence state once per decoded byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= '0;
		end else if (s1_fire) begin
			seq_q <= seq_nxt;
		end
	end

	// Load a result only for bytes that produce one; drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= s1_fire && dec_res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && dec_res.emit) begin
			cp_s2  <= dec_res.codepoint;
			bad_s2 <= dec_res.malformed;
		end
	end

	assign out_valid = valid_s2;
	assign codepoint = cp_s2;
	assign malformed = bad_s2;

endmodule

>>> hw/rtl/utf8d_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_decode: one-byte UTF-8 decode step
// Combinational update of the sequence state for one byte, and the codepoint
// it completes, if any.
// ----------------------------------------------------------------------------
module utf8d_decode
	import utf8d_pkg::*;
(
	input  logic [7:0]    text_byte,
	input  logic          end_of_text,
	input  utf8d_state_t  cur,
	output utf8d_state_t  nxt,
	output utf8d_result_t res
);

	logic [CP_W-1:0]   acc;
	logic [PEND_W-1:0] pend_dec;

	assign acc      = {cur.bits, text_byte[5:0]};
	assign pend_dec = cur.pending - PEND_W'(1);

	always_comb begin
		nxt           = cur;
		res.emit      = 1'b0;
		res.codepoint = INVALID_CP;
		res.malformed = 1'b0;
		if (cur.pending == '0) begin
			case (text_byte) inside
				8'b0???????: begin
					res.emit      = 1'b1;
					res.codepoint = CP_W'(text_byte);
				end
				8'b110?????: begin
					nxt.pending = PEND_W'(1);
					nxt.bits    = PARTIAL_W'(text_byte[4:0]);
				end
				8'b1110????: begin
					nxt.pending = PEND_W'(2);
					nxt.bits    = PARTIAL_W'(text_byte[3:0]);
				end
				8'b11110???: begin
					nxt.pending = PEND_W'(3);
					nxt.bits    = PARTIAL_W'(text_byte[2:0]);
				end
				default: begin
					// stray continuation or 11111xxx in lead position
					res.emit      = 1'b1;
					res.malformed = 1'b1;
				end
			endcase
			// lead byte flagged last leaves the sequence truncated
			if (nxt.pending != '0 && end_of_text) begin
				nxt           = '0;
				res.emit      = 1'b1;
				res.malformed = 1'b1;
			end
		end else if (text_byte[7:6] != 2'b10) begin
			// consume the bad byte and close the sequence
			nxt           = '0;
			res.emit      = 1'b1;
			res.malformed = 1'b1;
		end else if (pend_dec == '0) begin
			nxt           = '0;
			res.emit      = 1'b1;
			res.codepoint = acc;
		end else begin
			nxt.pending = pend_dec;
			nxt.bits    = acc[PARTIAL_W-1:0];
			if (end_of_text) begin
				nxt           = '0;
				res.emit      = 1'b1;
				res.malformed = 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/utf8d_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_checker: port-level checks for the UTF-8 codepoint decoder
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module utf8d_checker
	import utf8d_pkg::*;
(
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input logic [7:0]      text_byte,
	input logic            out_valid,
	input logic            out_ready,
	input logic [CP_W-1:0] codepoint,
	input logic            malformed
);

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(codepoint) && $stable(malformed))
		else $error("result changed while stalled");

	// the malformed marker always carries the replacement codepoint
	a_bad_cp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && malformed |-> codepoint == INVALID_CP)
		else $error("malformed result without replacement codepoint");

	// input back-pressure only ever comes from a stalled output
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled while output side is free");

	// an ASCII byte accepted on an idle block passes the input register and then the
	// result register, after which it is seen valid on the output
	a_ascii_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !text_byte[7] && !out_valid && $past(!in_valid || !in_ready)
		&& $past(!out_valid) && $past(in_ready)
		|=> ##1 out_valid)
		else $error("ASCII byte not returned in time");

endmodule

bind utf8_codepoint_decoder utf8d_checker u_utf8d_checker (.*);
